>>> hw/rtl/jdc_pkg.sv
// Shared constants, types and tables of the Julian day to calendar converter.
package jdc_pkg;

    localparam int DAY_BITS      = 24;
    localparam int FRACTION_BITS = 32;
    localparam int SEC_FRAC_BITS = 16;

    // Register stages from input to output register.
    localparam int NUM_STAGES = 10;

    localparam int WEEKDAY_W = 3;
    localparam int YEAR_W    = 17;
    localparam int MONTH_W   = 4;
    localparam int DOM_W     = 5;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int SECOND_W  = 6;

    // Width of c - e, the day count from the March-based year start.
    localparam int DAY_IN_YEAR_W = 9;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } jdc_ctrl_t;

    // Days before month index f in the March-based year, floor(30.6001 * f).
    function automatic logic [DAY_IN_YEAR_W-1:0] days_before_month(input logic [3:0] f);
        logic [DAY_IN_YEAR_W-1:0] days;
        case (f)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd30;
            4'd2:    days = 9'd61;
            4'd3:    days = 9'd91;
            4'd4:    days = 9'd122;
            4'd5:    days = 9'd153;
            4'd6:    days = 9'd183;
            4'd7:    days = 9'd214;
            4'd8:    days = 9'd244;
            4'd9:    days = 9'd275;
            4'd10:   days = 9'd306;
            4'd11:   days = 9'd336;
            4'd12:   days = 9'd367;
            4'd13:   days = 9'd397;
            4'd14:   days = 9'd428;
            4'd15:   days = 9'd459;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

>>> hw/rtl/julian_day_to_calendar_unit.sv
// Top level of the Julian day number to calendar date and time converter.
//
//   Channel | Handshake           | Payload
//   --------+---------------------+--------------------------------------------
//   input   | in_valid, in_ready  | day_number, day_fraction
//   output  | out_valid, out_ready| weekday, year, month, day_of_month, hour,
//           |                     | minute, second_whole, second_fraction
//
// The pipeline has ten register stages and accepts one transaction per cycle
// while the output is not stalled; the three reciprocal multiplies of the date
// path set the stage count.
// Reset clears only the stage valid bits; the datapath registers are not reset.
// When out_ready is low each full stage holds, and empty stages ahead of it
// keep filling, so in_ready stays high until every stage is occupied.
module julian_day_to_calendar_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [jdc_pkg::DAY_BITS-1:0]         day_number,
    input  logic [jdc_pkg::FRACTION_BITS-1:0]    day_fraction,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [jdc_pkg::WEEKDAY_W-1:0]        weekday,
    output logic signed [jdc_pkg::YEAR_W-1:0]    year,
    output logic [jdc_pkg::MONTH_W-1:0]          month,
    output logic [jdc_pkg::DOM_W-1:0]            day_of_month,
    output logic [jdc_pkg::HOUR_W-1:0]           hour,
    output logic [jdc_pkg::MINUTE_W-1:0]         minute,
    output logic [jdc_pkg::SECOND_W-1:0]         second_whole,
    output logic [jdc_pkg::SEC_FRAC_BITS-1:0]    second_fraction
);
    import jdc_pkg::*;

    jdc_ctrl_t ctrl;

    jdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctrl      (ctrl)
    );

    jdc_date u_date (
        .clk          (clk),
        .ctrl         (ctrl),
        .day_number   (day_number),
        .weekday      (weekday),
        .year         (year),
        .month        (month),
        .day_of_month (day_of_month)
    );

    jdc_time u_time (
        .clk             (clk),
        .ctrl            (ctrl),
        .day_fraction    (day_fraction),
        .hour            (hour),
        .minute          (minute),
        .second_whole    (second_whole),
        .second_fraction (second_fraction)
    );

endmodule

>>> hw/rtl/jdc_ctrl.sv
// Valid tracking and per-stage load enables for the conversion pipeline.
module jdc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output jdc_pkg::jdc_ctrl_t ctrl
);
    import jdc_pkg::*;

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_ready;
    logic [NUM_STAGES-1:0] upstream_valid;

    // A stage takes new data when it is empty or its own contents move on.
    always_comb
    begin
        stage_ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i+1];
        end
        upstream_valid = {valid_reg[NUM_STAGES-2:0], in_valid};
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            valid_next[i]  = stage_ready[i] ? upstream_valid[i] : valid_reg[i];
            ctrl.load[i]   = stage_ready[i] && upstream_valid[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

endmodule

>>> hw/rtl/jdc_date.sv
// Date datapath: weekday, year, month and day of month from the day number.
module jdc_date (
    input  logic                                  clk,
    input  jdc_pkg::jdc_ctrl_t                    ctrl,
    input  logic [jdc_pkg::DAY_BITS-1:0]          day_number,
    output logic [jdc_pkg::WEEKDAY_W-1:0]         weekday,
    output logic signed [jdc_pkg::YEAR_W-1:0]     year,
    output logic [jdc_pkg::MONTH_W-1:0]           month,
    output logic [jdc_pkg::DOM_W-1:0]             day_of_month
);
    import jdc_pkg::*;

    localparam int GREG_START = 2299161;

    // b = floor((4a - 7468865) / 146097), exact reciprocal multiply.
    localparam int N1_W = DAY_BITS + 2;
    localparam int K1   = N1_W + 18;
    localparam int M1_W = N1_W + 1;
    localparam int P1_W = N1_W + M1_W;
    localparam int B_W  = N1_W - 17;
    localparam logic [63:0] M1_FULL = ((64'd1 << K1) + 64'd146097 - 64'd1) / 64'd146097;
    localparam logic [M1_W-1:0] M1  = M1_FULL[M1_W-1:0];

    localparam int C_W = DAY_BITS + 1;

    // d = floor((20c - 2442) / 7305).
    localparam int N2_W = C_W + 5;
    localparam int K2   = N2_W + 13;
    localparam int M2_W = N2_W + 1;
    localparam int P2_W = N2_W + M2_W;
    localparam int D_W  = N2_W - 12;
    localparam logic [63:0] M2_FULL = ((64'd1 << K2) + 64'd7305 - 64'd1) / 64'd7305;
    localparam logic [M2_W-1:0] M2  = M2_FULL[M2_W-1:0];

    // f = floor(10000 g / 306001) with g below 512.
    localparam int N3_W = 23;
    localparam int K3   = N3_W + 19;
    localparam int M3_W = N3_W + 1;
    localparam int P3_W = N3_W + M3_W;
    localparam logic [63:0] M3_FULL = ((64'd1 << K3) + 64'd306001 - 64'd1) / 64'd306001;
    localparam logic [M3_W-1:0] M3  = M3_FULL[M3_W-1:0];

    // The day of the year only needs the low bits of c and of 1461 d / 4.
    localparam int G_W  = DAY_IN_YEAR_W;
    localparam int PE_W = G_W + 2;

    // Weekday as a sum of octal digits, since 8 is 1 mod 7.
    localparam int WK_IN_W  = DAY_BITS + 1;
    localparam int WK_CH    = (WK_IN_W + 2) / 3;
    localparam int WK_PAD_W = 3 * WK_CH;
    localparam int WK_SUM_W = $clog2(7 * WK_CH + 1);

    localparam int LAST = NUM_STAGES - 1;

    // Stage 0
    logic [DAY_BITS-1:0] a0_reg;
    logic                greg0_reg;
    logic                greg0_next;
    logic [N1_W-1:0]     n1_0_reg;
    logic [N1_W-1:0]     n1_0_next;
    logic [WK_SUM_W-1:0] wsum0_reg;
    logic [WK_SUM_W-1:0] wsum0_next;
    logic [WK_IN_W-1:0]  wk_plus_one;
    logic [WK_PAD_W-1:0] wk_pad;

    // Stage 1
    logic [DAY_BITS-1:0] a1_reg;
    logic                greg1_reg;
    logic [B_W-1:0]      b1_reg;
    logic [B_W-1:0]      b1_next;
    logic [P1_W-1:0]     prod1;
    logic [4:0]          fold_u;
    logic [3:0]          fold_v;
    logic [3:0]          fold_w;
    logic [WEEKDAY_W-1:0] wk1_next;

    // Weekday carried from stage 1 to the output.
    logic [WEEKDAY_W-1:0] wk_reg [1:LAST];

    // Stages 2 to 4
    logic [C_W-1:0]  c2_reg;
    logic [C_W-1:0]  c2_next;
    logic [N2_W-1:0] n2_3_reg;
    logic [N2_W-1:0] n2_3_next;
    logic [G_W-1:0]  c_low_reg [3:5];
    logic [D_W-1:0]  d4_reg;
    logic [D_W-1:0]  d4_next;
    logic [P2_W-1:0] prod2;

    // Stages 5 to 8
    logic [PE_W-1:0]   pe5_reg;
    logic [PE_W-1:0]   pe5_next;
    logic [YEAR_W-1:0] dy_reg [5:LAST-1];
    logic [G_W-1:0]    g_reg [6:LAST-1];
    logic [G_W-1:0]    g6_next;
    logic [N3_W-1:0]   n3_7_reg;
    logic [N3_W-1:0]   n3_7_next;
    logic [3:0]        f8_reg;
    logic [3:0]        f8_next;
    logic [P3_W-1:0]   prod3;

    // Output stage
    logic [MONTH_W-1:0] month_reg;
    logic [MONTH_W-1:0] month_next;
    logic [DOM_W-1:0]   dom_reg;
    logic [DOM_W-1:0]   dom_next;
    logic [YEAR_W-1:0]  year_reg;
    logic [YEAR_W-1:0]  year_next;
    logic               after_feb;

    always_comb
    begin
        greg0_next  = day_number >= DAY_BITS'(GREG_START);
        n1_0_next   = {day_number, 2'b00} - N1_W'(7468865);
        wk_plus_one = WK_IN_W'(day_number) + WK_IN_W'(1);
        wk_pad      = WK_PAD_W'(wk_plus_one);
        wsum0_next  = '0;
        for (int i = 0; i < WK_CH; i++)
        begin
            wsum0_next = wsum0_next + WK_SUM_W'(wk_pad[3*i +: 3]);
        end
    end

    always_comb
    begin
        prod1    = P1_W'(n1_0_reg) * P1_W'(M1);
        b1_next  = prod1[K1 +: B_W];
        fold_u   = 5'(wsum0_reg[2:0]) + 5'(wsum0_reg[WK_SUM_W-1:3]);
        fold_v   = 4'(fold_u[2:0]) + 4'(fold_u[4:3]);
        fold_w   = 4'(fold_v[2:0]) + 4'(fold_v[3]);
        wk1_next = (fold_w >= 4'd7) ? 3'(fold_w - 4'd7) : fold_w[2:0];
    end

    always_comb
    begin
        if (greg1_reg)
        begin
            c2_next = C_W'(a1_reg) + C_W'(b1_reg) - C_W'(b1_reg >> 2) + C_W'(1525);
        end
        else
        begin
            c2_next = C_W'(a1_reg) + C_W'(1524);
        end
        n2_3_next = N2_W'({c2_reg, 4'b0000}) + N2_W'({c2_reg, 2'b00}) - N2_W'(2442);
        prod2     = P2_W'(n2_3_reg) * P2_W'(M2);
        d4_next   = prod2[K2 +: D_W];
        pe5_next  = PE_W'(d4_reg[PE_W-1:0] * PE_W'(1461));
        g6_next   = c_low_reg[5] - pe5_reg[PE_W-1:2];
        n3_7_next = N3_W'(g_reg[6]) * N3_W'(10000);
        prod3     = P3_W'(n3_7_reg) * P3_W'(M3);
        f8_next   = prod3[K3 +: 4];
    end

    always_comb
    begin
        month_next = (f8_reg < 4'd14) ? (f8_reg - 4'd1) : (f8_reg - 4'd13);
        dom_next   = DOM_W'(g_reg[LAST-1] - days_before_month(f8_reg));
        after_feb  = month_next > 4'd2;
        year_next  = dy_reg[LAST-1] - YEAR_W'(4715) - YEAR_W'(after_feb);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            a0_reg    <= day_number;
            greg0_reg <= greg0_next;
            n1_0_reg  <= n1_0_next;
            wsum0_reg <= wsum0_next;
        end
        if (ctrl.load[1])
        begin
            a1_reg    <= a0_reg;
            greg1_reg <= greg0_reg;
            b1_reg    <= b1_next;
            wk_reg[1] <= wk1_next;
        end
        for (int i = 2; i <= LAST; i++)
        begin
            if (ctrl.load[i])
            begin
                wk_reg[i] <= wk_reg[i-1];
            end
        end
        if (ctrl.load[2])
        begin
            c2_reg <= c2_next;
        end
        if (ctrl.load[3])
        begin
            n2_3_reg     <= n2_3_next;
            c_low_reg[3] <= c2_reg[G_W-1:0];
        end
        if (ctrl.load[4])
        begin
            d4_reg       <= d4_next;
            c_low_reg[4] <= c_low_reg[3];
        end
        if (ctrl.load[5])
        begin
            pe5_reg      <= pe5_next;
            dy_reg[5]    <= YEAR_W'(d4_reg);
            c_low_reg[5] <= c_low_reg[4];
        end
        if (ctrl.load[6])
        begin
            g_reg[6]  <= g6_next;
            dy_reg[6] <= dy_reg[5];
        end
        if (ctrl.load[7])
        begin
            n3_7_reg  <= n3_7_next;
            g_reg[7]  <= g_reg[6];
            dy_reg[7] <= dy_reg[6];
        end
        if (ctrl.load[8])
        begin
            f8_reg    <= f8_next;
            g_reg[8]  <= g_reg[7];
            dy_reg[8] <= dy_reg[7];
        end
        if (ctrl.load[LAST])
        begin
            month_reg <= month_next;
            dom_reg   <= dom_next;
            year_reg  <= year_next;
        end
    end

    assign weekday      = wk_reg[LAST];
    assign year         = year_reg;
    assign month        = month_reg;
    assign day_of_month = dom_reg;

endmodule

>>> hw/rtl/jdc_time.sv
// Time-of-day datapath: hour, minute, seconds and second fraction.
module jdc_time (
    input  logic                                 clk,
    input  jdc_pkg::jdc_ctrl_t                   ctrl,
    input  logic [jdc_pkg::FRACTION_BITS-1:0]    day_fraction,
    output logic [jdc_pkg::HOUR_W-1:0]           hour,
    output logic [jdc_pkg::MINUTE_W-1:0]         minute,
    output logic [jdc_pkg::SECOND_W-1:0]         second_whole,
    output logic [jdc_pkg::SEC_FRAC_BITS-1:0]    second_fraction
);
    import jdc_pkg::*;

    localparam int F       = FRACTION_BITS;
    localparam int HOLD    = NUM_STAGES - 3;
    localparam int ST_HOUR = NUM_STAGES - 3;
    localparam int ST_MIN  = NUM_STAGES - 2;
    localparam int ST_SEC  = NUM_STAGES - 1;

    logic [F-1:0] frac_reg [0:HOLD-1];

    logic [F+4:0]        t_hour;
    logic [F+5:0]        t_min;
    logic [F+5:0]        t_sec;

    logic [HOUR_W-1:0]   hour_reg [ST_HOUR:ST_SEC];
    logic [F-1:0]        rem_hour_reg;
    logic [MINUTE_W-1:0] min_reg [ST_MIN:ST_SEC];
    logic [F-1:0]        rem_min_reg;
    logic [SECOND_W-1:0] sec_reg;
    logic [SEC_FRAC_BITS-1:0] sfrac_reg;

    // Each step scales the leftover fraction and peels off the integer part.
    always_comb
    begin
        t_hour = (F+5)'(frac_reg[HOLD-1]) * (F+5)'(24);
        t_min  = (F+6)'(rem_hour_reg) * (F+6)'(60);
        t_sec  = (F+6)'(rem_min_reg) * (F+6)'(60);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load[0])
        begin
            frac_reg[0] <= day_fraction;
        end
        for (int i = 1; i < HOLD; i++)
        begin
            if (ctrl.load[i])
            begin
                frac_reg[i] <= frac_reg[i-1];
            end
        end
        if (ctrl.load[ST_HOUR])
        begin
            hour_reg[ST_HOUR] <= t_hour[F +: HOUR_W];
            rem_hour_reg      <= t_hour[F-1:0];
        end
        if (ctrl.load[ST_MIN])
        begin
            hour_reg[ST_MIN] <= hour_reg[ST_HOUR];
            min_reg[ST_MIN]  <= t_min[F +: MINUTE_W];
            rem_min_reg      <= t_min[F-1:0];
        end
        if (ctrl.load[ST_SEC])
        begin
            hour_reg[ST_SEC] <= hour_reg[ST_MIN];
            min_reg[ST_SEC]  <= min_reg[ST_MIN];
            sec_reg          <= t_sec[F +: SECOND_W];
            sfrac_reg        <= t_sec[F-1 -: SEC_FRAC_BITS];
        end
    end

    assign hour            = hour_reg[ST_SEC];
    assign minute          = min_reg[ST_SEC];
    assign second_whole    = sec_reg;
    assign second_fraction = sfrac_reg;

endmodule
